### design/assert_macros.svh
// Assertion macros for the checker file of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AEAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aear assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define AEAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aear assertion failed");

`endif

### design/aear_pkg.sv
// Package for the action edge and auto-repeat unit: widths, entry type,
// sequencer states and register indexes. No dependencies.
package aear_pkg;

  localparam int ACTIONS_DEF  = 64;
  localparam int MASK_W       = 64;
  localparam int HELD_W       = 32;
  localparam int LEFT_W       = 18;
  localparam int DT_W         = 16;
  localparam int QUERY_W      = 6;
  localparam int CFG_W        = 16;
  localparam int CFG_ADDR_W   = 1;
  // signed working width of the countdown arithmetic
  localparam int CNT_W        = 20;

  localparam int IN_TDATA_W   = 152;
  localparam int OUT_TDATA_W  = 288;

  localparam logic [CFG_W-1:0] DELAY_RST    = 16'd300;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd100;
  localparam logic [CFG_W-1:0] MIN_INTERVAL = 16'd10;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_DELAY    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL = 1'b1;

  // per-action stored state
  typedef struct packed {
    logic              dis;
    logic [LEFT_W-1:0] left;
    logic [HELD_W-1:0] held;
  } aear_entry_t;

  // per-action input bits handed to the update unit
  typedef struct packed {
    logic pressed;
    logic prev_held;
  } aear_act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LAST,
    ST_DONE
  } aear_state_t;

endpackage

### design/aear_mem.sv
// Per-action state memory: one write port, one registered read port,
// valid bits so that unwritten entries read as zero. Uses aear_pkg.
module aear_mem #(
  parameter int DEPTH = aear_pkg::ACTIONS_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  aear_pkg::aear_entry_t wr_data,
  output aear_pkg::aear_entry_t rd_data
);
  import aear_pkg::*;

  aear_entry_t             mem_r [DEPTH];
  logic [DEPTH-1:0]        valid_r;
  aear_entry_t             rd_data_r;
  logic                    rd_vld_r;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### design/aear_upd.sv
// Shared per-action update unit: held-time accumulate and repeat countdown
// for one action per cycle. Uses aear_pkg.
module aear_upd (
  input  aear_pkg::aear_entry_t          cur,
  input  aear_pkg::aear_act_t            act,
  input  logic [aear_pkg::DT_W-1:0]      dt,
  input  logic [aear_pkg::CFG_W-1:0]     delay,
  input  logic [aear_pkg::CFG_W-1:0]     interval,
  output aear_pkg::aear_entry_t          nxt,
  output logic                           rep
);
  import aear_pkg::*;

  logic [HELD_W-1:0]       held_base;
  logic [HELD_W:0]         held_sum;
  logic                    dis;
  logic signed [CNT_W-1:0] r1;
  logic signed [CNT_W-1:0] r2;
  logic                    r1_pos;
  logic                    r2_pos;

  always_comb begin
    // not held on the previous update (and no press): held restarts and disarms
    held_base = act.prev_held ? cur.held : '0;
    dis       = act.prev_held ? cur.dis : 1'b1;
    held_sum  = {1'b0, held_base} + {{(HELD_W + 1 - DT_W){1'b0}}, dt};
    r1 = $signed({{(CNT_W - LEFT_W){1'b0}}, cur.left}) - $signed({{(CNT_W - DT_W){1'b0}}, dt});
    r2 = r1 + $signed({{(CNT_W - CFG_W){1'b0}}, interval});
    r1_pos = !r1[CNT_W-1] && (r1 != '0);
    r2_pos = !r2[CNT_W-1] && (r2 != '0);

    nxt = cur;
    rep = 1'b0;
    if (act.pressed) begin
      nxt.held = '0;
      nxt.left = LEFT_W'(delay);
      nxt.dis  = 1'b0;
      rep      = 1'b1;
    end else begin
      nxt.held = held_sum[HELD_W] ? '1 : held_sum[HELD_W-1:0];
      nxt.dis  = dis;
      if (!dis) begin
        if (r1_pos) begin
          nxt.left = r1[LEFT_W-1:0];
        end else begin
          // countdown expired: repeat, then reload (once per long frame)
          rep      = 1'b1;
          nxt.left = r2_pos ? r2[LEFT_W-1:0] : LEFT_W'(interval);
        end
      end
    end
  end

endmodule

### design/action_edge_and_autorepeat_unit.sv
// Top level of the action edge and auto-repeat unit: capture, sequencer,
// output register. Uses aear_pkg, aear_mem, aear_upd.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata: held, pressed, elapsed, query
//  out_    | out | out_tvalid/tready  | out_tdata: 4 masks, query held time
//  cfg_    | in  | cfg_we             | cfg_addr, cfg_wdata (16 bit)
//
// After acceptance the sequencer walks every action entry once through the state
// memory (one write port, one registered read port) and the shared update unit,
// one entry per cycle, in states RUN and LAST, then loads the result in DONE.
// in_tready is high only while the sequencer is idle; a result waiting on
// out_tready does not block acceptance of the next update, but the next
// result waits in DONE until the output register frees.
// Reset (synchronous, active low) clears control, prev_held_r and memory valid bits.
module action_edge_and_autorepeat_unit #(
  parameter int ACTIONS = aear_pkg::ACTIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // held_now[63:0], pressed_now[127:64], elapsed_ms[143:128], query_action[149:144]
  input  logic [aear_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pressed_mask[63:0], released_mask[127:64], held_mask[191:128],
  // repeat_mask[255:192], query_held_ms[287:256]
  output logic [aear_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [aear_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [aear_pkg::CFG_W-1:0]         cfg_wdata
);
  import aear_pkg::*;

  localparam int IDX_W = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;

  aear_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]     s1_idx_r, s1_idx_nxt;

  logic [CFG_W-1:0]     delay_r;
  logic [CFG_W-1:0]     interval_r;
  logic [CFG_W-1:0]     interval_eff;

  logic [ACTIONS-1:0]   now_r;
  logic [ACTIONS-1:0]   pr_r;
  logic [ACTIONS-1:0]   prev_held_r;
  logic [ACTIONS-1:0]   rel_r;
  logic [ACTIONS-1:0]   rep_r, rep_nxt;
  logic [DT_W-1:0]      dt_r;
  logic [QUERY_W-1:0]   q_r;
  logic [HELD_W-1:0]    qval_r, qval_nxt;

  logic [ACTIONS-1:0]   in_now;
  logic [ACTIONS-1:0]   in_pr;
  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic                 rd_en;
  logic                 s1_active;
  logic                 wr_en;
  logic                 upd_rep;
  aear_entry_t          rd_data;
  aear_entry_t          upd_nxt;
  aear_act_t            upd_act;

  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tvalid_r;

  assign in_now   = in_tdata[ACTIONS-1:0];
  assign in_pr    = in_tdata[MASK_W +: ACTIONS];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= DELAY_RST;
      interval_r <= INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DELAY:    delay_r    <= cfg_wdata;
        CFG_INTERVAL: interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign interval_eff = (interval_r < MIN_INTERVAL) ? MIN_INTERVAL : interval_r;

  // sequencer: next state and controls
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    s1_vld_nxt = 1'b0;
    s1_idx_nxt = s1_idx_r;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_idx_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rd_en      = 1'b1;
        s1_vld_nxt = 1'b1;
        s1_idx_nxt = rd_idx_r;
        if (rd_idx_r == IDX_W'(ACTIONS - 1)) begin
          state_nxt = ST_LAST;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_LAST: begin
        // last entry is in the update stage this cycle
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
      s1_vld_r <= 1'b0;
      s1_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      s1_vld_r <= s1_vld_nxt;
      s1_idx_r <= s1_idx_nxt;
    end
  end

  // previous held mask; the walk reads it, so it takes the new mask
  // once the last entry has been updated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_held_r <= '0;
    end else if (state_r == ST_LAST) begin
      prev_held_r <= now_r;
    end
  end

  // input capture; edge masks settle at acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_now;
      pr_r  <= in_pr;
      rel_r <= (prev_held_r & ~in_now) | (in_pr & ~in_now);
      dt_r  <= in_tdata[2*MASK_W +: DT_W];
      q_r   <= in_tdata[2*MASK_W + DT_W +: QUERY_W];
    end
  end

  // per-entry update stage
  assign s1_active         = now_r[s1_idx_r] || pr_r[s1_idx_r];
  assign wr_en             = s1_vld_r && s1_active;
  assign upd_act.pressed   = pr_r[s1_idx_r];
  assign upd_act.prev_held = prev_held_r[s1_idx_r];

  aear_mem #(
    .DEPTH (ACTIONS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (upd_nxt),
    .rd_data (rd_data)
  );

  aear_upd u_upd (
    .cur      (rd_data),
    .act      (upd_act),
    .dt       (dt_r),
    .delay    (delay_r),
    .interval (interval_eff),
    .nxt      (upd_nxt),
    .rep      (upd_rep)
  );

  // repeat mask and query capture
  always_comb begin
    rep_nxt  = rep_r;
    qval_nxt = qval_r;
    if (in_acc) begin
      rep_nxt  = '0;
      qval_nxt = '0;
    end else if (wr_en) begin
      rep_nxt[s1_idx_r] = upd_rep;
      if (now_r[s1_idx_r] && ((QUERY_W + 1)'(q_r) == (QUERY_W + 1)'(s1_idx_r))) begin
        qval_nxt = upd_nxt.held;
      end
    end
  end

  always_ff @(posedge clk) begin
    rep_r  <= rep_nxt;
    qval_r <= qval_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {qval_r, MASK_W'(rep_r), MASK_W'(now_r), MASK_W'(rel_r), MASK_W'(pr_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### design/aear_chk.sv
// Port-level checker for the action edge and auto-repeat unit, bound to
// the top level. Uses assert_macros.svh.
`include "assert_macros.svh"

module aear_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [287:0] out_tdata
);

  // the walk over all entries makes the block busy right after acceptance
  `AEAR_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // no result can appear in the cycle right after an update is taken
  `AEAR_ASSERT_NXT(a_no_instant_out, clk, rst_n, in_tvalid && in_tready, !$rose(out_tvalid))

  // every fresh press is flagged as a repeat
  `AEAR_ASSERT_IMP(a_press_repeats, clk, rst_n, out_tvalid, (out_tdata[63:0] & ~out_tdata[255:192]) == 64'd0)

  // an action cannot be both released and held
  `AEAR_ASSERT_IMP(a_rel_held_excl, clk, rst_n, out_tvalid, (out_tdata[127:64] & out_tdata[191:128]) == 64'd0)

  // a stalled result keeps its payload
  `AEAR_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind action_edge_and_autorepeat_unit aear_chk u_aear_chk (.*);
